// ===== rtl/ouart_pkg.sv =====
// Shared constants and status types for the oversampled UART transceiver.
package ouart_pkg;

   localparam int unsigned TxShiftWidth = 16;
   localparam int unsigned RxCountWidth = 4;

   localparam logic [TxShiftWidth-1:0] TX_PREAMBLE   = 16'hD55F;
   localparam logic [TxShiftWidth-1:0] TX_FRAME_STOP = 16'h0200;
   localparam logic [RxCountWidth-1:0] RX_IDLE       = 4'd0;
   localparam logic [RxCountWidth-1:0] RX_FIRST_BIT  = 4'd1;
   localparam logic [RxCountWidth-1:0] RX_STOP_STAGE = 4'd9;

   // Transmitter result for one tick.
   typedef struct packed {
      logic line;
      logic busy;
      logic taken;
   } tx_status_type;

   // Receiver result for one tick.
   typedef struct packed {
      logic [7:0] data;
      logic       valid;
   } rx_status_type;

endpackage

// ===== rtl/oversampled_uart_transceiver.sv =====
// Top level of the 8N1 UART transceiver driven by a 4x baud-rate tick.
//
// Every item on the req_ channel is one oversampling tick: it carries the sampled
// receive line, an optional transmit byte with its load request, and an acknowledge
// for the received byte. Each tick yields exactly one rsp_ item holding the transmit
// line level, the last well-framed received byte with its valid flag, the busy
// status of the transmitter and whether this tick's load was taken. The block takes
// one tick per clock cycle: the state update and the result are computed in a
// single pass of shallow logic and the result lands in an output register, and a
// new tick is accepted in the same cycle that the waiting result is taken, so only
// a stall on the rsp_ side holds up the req_ side. After reset the transmitter
// sends the preamble 0xD55F (stop bits and a 0x55 autobaud character) before it
// takes a load. Loads offered while it is busy are ignored.
// A newly framed byte overwrites an unread one, and a low stop bit drops the frame.
module oversampled_uart_transceiver
   import ouart_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_rx_level,
   input  logic       req_load_tx,
   input  logic [7:0] req_tx_byte,
   input  logic       req_take_rx,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_tx_line,
   output logic [7:0] rsp_rx_byte,
   output logic       rsp_rx_valid,
   output logic       rsp_tx_busy,
   output logic       rsp_load_taken
);

   logic          req_accept;
   logic [1:0]    phase_ff, phase_in;
   logic          rsp_valid_ff, rsp_valid_in;
   tx_status_type tx_status;
   rx_status_type rx_status;
   tx_status_type tx_out_ff;
   rx_status_type rx_out_ff;

   // The output register can take a new item when it is empty or being drained.
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // The shared phase counter advances once per tick; both halves see its new value.
   assign phase_in = phase_ff + 2'd1;

   ouart_tx u_tx (
      .clock      (clock),
      .reset      (reset),
      .step       (req_accept),
      .phase_zero (phase_in == 2'd0),
      .load_tx    (req_load_tx),
      .tx_byte    (req_tx_byte),
      .status     (tx_status)
   );

   ouart_rx u_rx (
      .clock      (clock),
      .reset      (reset),
      .step       (req_accept),
      .phase_next (phase_in),
      .rx_level   (req_rx_level),
      .take_rx    (req_take_rx),
      .status     (rx_status)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            phase_ff <= phase_in;
         end
      end
   end

   // Result payload needs no reset; it is qualified by rsp_valid.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         tx_out_ff <= tx_status;
         rx_out_ff <= rx_status;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tx_line    = tx_out_ff.line;
   assign rsp_rx_byte    = rx_out_ff.data;
   assign rsp_rx_valid   = rx_out_ff.valid;
   assign rsp_tx_busy    = tx_out_ff.busy;
   assign rsp_load_taken = tx_out_ff.taken;

   // An empty output register never holds off the request side.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> !req_stall)
      else $error("request stalled with empty output register");

   // Every accepted tick leaves a result waiting in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted tick produced no result");

   // A freshly loaded frame still has bits to send after its first tick.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && tx_out_ff.taken) |-> tx_out_ff.busy)
      else $error("load taken but transmitter reported idle");

   // The phase counter moves by one on every accepted tick and holds otherwise.
   assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> (phase_ff == $past(phase_ff)))
      else $error("phase counter moved without a tick");

endmodule

// ===== rtl/ouart_tx.sv =====
// Transmit shift register with frame loading and phase-zero bit output.
module ouart_tx
   import ouart_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  logic          phase_zero,
   input  logic          load_tx,
   input  logic [7:0]    tx_byte,
   output tx_status_type status
);

   logic [TxShiftWidth-1:0] shift_ff;
   logic [TxShiftWidth-1:0] shift_in;
   logic                    level_ff;
   logic                    level_in;
   logic [TxShiftWidth-1:0] loaded;
   logic                    taken;
   logic                    fire;

   always_comb begin
      taken    = load_tx && (shift_ff == '0);
      // A frame is the byte with a low start bit below and a high stop bit above.
      loaded   = taken ? (TX_FRAME_STOP | {7'd0, tx_byte, 1'b0}) : shift_ff;
      fire     = (loaded != '0) && phase_zero;
      shift_in = fire ? (loaded >> 1) : loaded;
      level_in = fire ? loaded[0] : level_ff;
      status.line  = level_in;
      status.busy  = (shift_in != '0);
      status.taken = taken;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= TX_PREAMBLE;
         level_ff <= 1'b1;
      end else if (step) begin
         shift_ff <= shift_in;
         level_ff <= level_in;
      end
   end

endmodule

// ===== rtl/ouart_rx.sv =====
// Receiver: start detection, phase-locked data sampling and stop-bit check.
module ouart_rx
   import ouart_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  logic [1:0]    phase_next,
   input  logic          rx_level,
   input  logic          take_rx,
   output rx_status_type status
);

   logic [1:0]              offset_ff, offset_in;
   logic [7:0]              shift_ff, shift_in;
   logic [RxCountWidth-1:0] count_ff, count_in;
   logic [7:0]              hold_ff, hold_in;
   logic                    flag_ff, flag_in;

   always_comb begin
      offset_in = offset_ff;
      shift_in  = shift_ff;
      count_in  = count_ff;
      hold_in   = hold_ff;
      // An acknowledge clears the flag before this tick can set it again.
      flag_in   = take_rx ? 1'b0 : flag_ff;
      if (count_ff == RX_IDLE) begin
         if (!rx_level) begin
            count_in  = RX_FIRST_BIT;
            offset_in = phase_next;
         end
      end else if (phase_next == offset_ff) begin
         if (count_ff < RX_STOP_STAGE) begin
            shift_in = {rx_level, shift_ff[7:1]};
            count_in = count_ff + RX_FIRST_BIT;
         end else begin
            // A low stop bit drops the frame without a trace.
            if (rx_level) begin
               hold_in = shift_ff;
               flag_in = 1'b1;
            end
            count_in = RX_IDLE;
         end
      end
      status.data  = hold_in;
      status.valid = flag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         shift_ff  <= '0;
         count_ff  <= RX_IDLE;
         hold_ff   <= '0;
         flag_ff   <= 1'b0;
      end else if (step) begin
         offset_ff <= offset_in;
         shift_ff  <= shift_in;
         count_ff  <= count_in;
         hold_ff   <= hold_in;
         flag_ff   <= flag_in;
      end
   end

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the oversampled UART transceiver.
`timescale 1ns / 100ps

module tb
   import ouart_pkg::*;
();

   // Cycles with no accepted item on either channel before the run is declared hung.
   localparam int StallLimit = 1000;
   // Number of oversampling ticks the stimulus aims for.
   localparam int TickTarget = 1000;

   // One oversampling tick as the sender offers it, plus pacing hints for the driver.
   typedef struct {
      logic       rx_level;
      logic       load_tx;
      logic [7:0] tx_byte;
      logic       take_rx;
      bit         settle_first;  // hold this tick back until every result is in
      bit         quiet;         // no idle cycles after this tick
   } line_tick_type;

   // Everything the transceiver reports after one tick.
   typedef struct packed {
      logic       tx_line;
      logic [7:0] rx_byte;
      logic       rx_valid;
      logic       tx_busy;
      logic       load_taken;
   } line_status_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_rx_level = 1'b1;
   logic       req_load_tx = 1'b0;
   logic [7:0] req_tx_byte = 8'd0;
   logic       req_take_rx = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_tx_line;
   logic [7:0] rsp_rx_byte;
   logic       rsp_rx_valid;
   logic       rsp_tx_busy;
   logic       rsp_load_taken;

   wire req_fire = req_valid && !req_stall;
   wire rsp_fire = rsp_valid && !rsp_stall;

   // Ticks waiting to be sent and the statuses the transceiver still owes us.
   line_tick_type   tick_q[$];
   line_status_type status_due_q[$];

   // Our own copy of the transceiver state, advanced once per accepted tick.
   logic [1:0]              tick_phase;
   logic [1:0]              rx_sample_phase;
   logic [7:0]              rx_bits;
   logic [RxCountWidth-1:0] rx_stage;
   logic [TxShiftWidth-1:0] tx_bits;
   logic                    tx_out;
   logic [7:0]              rx_latched;
   logic                    rx_ready;

   int fail_count = 0;
   int idle_cycles = 0;
   int send_wait = 0;
   bit send_quiet = 1'b0;
   int hold_left = 0;
   bit take_quiet = 1'b0;
   int results_seen = 0;

   // Stimulus builder state.
   int ticks_made = 0;
   bit settle_next = 1'b0;
   bit quiet_now = 1'b0;

   oversampled_uart_transceiver dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_level   (req_rx_level),
      .req_load_tx    (req_load_tx),
      .req_tx_byte    (req_tx_byte),
      .req_take_rx    (req_take_rx),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_tx_line    (rsp_tx_line),
      .rsp_rx_byte    (rsp_rx_byte),
      .rsp_rx_valid   (rsp_rx_valid),
      .rsp_tx_busy    (rsp_tx_busy),
      .rsp_load_taken (rsp_load_taken)
   );

   always #10 clock = ~clock;

   // Advances the shadow transceiver by one tick and returns what it should report.
   // The order matters: the take clears the flag, then the load is considered, and
   // only then does the phase counter move and the line get shifted and sampled.
   function automatic line_status_type run_tick(input logic rx, input logic load,
                                                input logic [7:0] data, input logic take);
      line_status_type st;
      st.load_taken = 1'b0;
      if (take) begin
         rx_ready = 1'b0;
      end
      // A load only lands in an empty shift register; it gets a low start bit
      // below the data and a high stop bit above it.
      if (load && tx_bits == '0) begin
         tx_bits = {7'd0, data, 1'b0} | TX_FRAME_STOP;
         st.load_taken = 1'b1;
      end
      tick_phase = tick_phase + 2'd1;
      if (tx_bits != '0 && tick_phase == 2'd0) begin
         tx_out = tx_bits[0];
         tx_bits = tx_bits >> 1;
      end
      // The receiver samples each bit at the phase where the start edge was seen,
      // so a bit is taken on the first tick of its four.
      if (rx_stage == RX_IDLE) begin
         if (!rx) begin
            rx_stage = RX_FIRST_BIT;
            rx_sample_phase = tick_phase;
         end
      end else if (tick_phase == rx_sample_phase) begin
         if (rx_stage < RX_STOP_STAGE) begin
            rx_bits = {rx, rx_bits[7:1]};
            rx_stage = rx_stage + RX_FIRST_BIT;
         end else begin
            // A low stop bit is a framing error and the byte is thrown away.
            if (rx) begin
               rx_latched = rx_bits;
               rx_ready = 1'b1;
            end
            rx_stage = RX_IDLE;
         end
      end
      st.tx_line  = tx_out;
      st.rx_byte  = rx_latched;
      st.rx_valid = rx_ready;
      st.tx_busy  = (tx_bits != '0);
      return st;
   endfunction

   function automatic void check_field(input string what, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      end
   endfunction

   task automatic add_tick(input logic rx, input logic load, input logic [7:0] data,
                           input logic take);
      line_tick_type t;
      t.rx_level = rx;
      t.load_tx = load;
      t.tx_byte = data;
      t.take_rx = take;
      t.settle_first = settle_next;
      t.quiet = quiet_now;
      settle_next = 1'b0;
      tick_q.push_back(t);
      ticks_made++;
   endtask

   // A tick with the given receive level and random transmit and take requests.
   task automatic add_line(input logic rx);
      add_tick(rx, $urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)),
               $urandom_range(0, 5) == 0);
   endtask

   // One 8N1 frame on the receive line, four ticks per bit.
   task automatic send_frame(input logic [7:0] data, input logic stop);
      logic [9:0] frame;
      frame = {stop, data, 1'b0};
      for (int b = 0; b < 10; b++) begin
         repeat (4) add_line(frame[b]);
      end
   endtask

   // The driver presents the next queued tick. It only ever makes one nonblocking
   // assignment per signal in a step, so a valid that stays high is never lowered
   // and raised in the same edge.
   task automatic present_tick();
      line_tick_type t;
      t = tick_q.pop_front();
      req_valid    <= 1'b1;
      req_rx_level <= t.rx_level;
      req_load_tx  <= t.load_tx;
      req_tx_byte  <= t.tx_byte;
      req_take_rx  <= t.take_rx;
      send_quiet = t.quiet;
   endtask

   // Driver. The expected status is computed at the edge where a tick is accepted,
   // from the values that were on the req_ ports before that edge.
   always @(posedge clock) begin : driver
      int gap;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= 0;
         tick_phase = 2'd0;
         rx_sample_phase = 2'd0;
         rx_bits = 8'd0;
         rx_stage = RX_IDLE;
         tx_bits = TX_PREAMBLE;
         tx_out = 1'b1;
         rx_latched = 8'd0;
         rx_ready = 1'b0;
      end else if (req_fire) begin
         status_due_q.push_back(run_tick(req_rx_level, req_load_tx, req_tx_byte,
                                         req_take_rx));
         gap = send_quiet ? 0 : $urandom_range(0, 3);
         // A tick that must wait for the results to settle always goes through the
         // idle path, where the queue of owed statuses can be judged cleanly.
         if (gap == 0 && tick_q.size() != 0 && !tick_q[0].settle_first) begin
            present_tick();
         end else begin
            // The cycle with valid low already counts as the first idle cycle.
            req_valid <= 1'b0;
            send_wait <= (gap > 0) ? gap - 1 : 0;
         end
      end else if (!req_valid) begin
         if (send_wait != 0) begin
            send_wait <= send_wait - 1;
         end else if (tick_q.size() != 0 &&
                      (!tick_q[0].settle_first || status_due_q.size() == 0 ||
                       (status_due_q.size() == 1 && rsp_fire))) begin
            // The last term counts a status that the monitor takes at this very
            // edge as already in, whichever block runs first.
            present_tick();
         end
      end
   end

   // Monitor. Every accepted status is matched against the oldest one owed, and
   // the receive side draws its own stall for each item it takes.
   always @(posedge clock) begin : monitor
      line_status_type want;
      int hold;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else begin
         if (rsp_fire) begin
            if (status_due_q.size() == 0) begin
               fail_count++;
               $display("%0t ns: status item with none expected, got tx_line %0h", $time,
                        rsp_tx_line);
            end else begin
               want = status_due_q.pop_front();
               check_field("tx_line", {7'd0, want.tx_line}, {7'd0, rsp_tx_line});
               check_field("rx_byte", want.rx_byte, rsp_rx_byte);
               check_field("rx_valid", {7'd0, want.rx_valid}, {7'd0, rsp_rx_valid});
               check_field("tx_busy", {7'd0, want.tx_busy}, {7'd0, rsp_tx_busy});
               check_field("load_taken", {7'd0, want.load_taken},
                           {7'd0, rsp_load_taken});
            end
            results_seen++;
            // Now and then the receiver runs flat out for a while.
            if (results_seen % 64 == 0) begin
               take_quiet = ($urandom_range(0, 3) == 0);
            end
            hold = take_quiet ? 0 : $urandom_range(0, 3);
            hold_left <= hold;
            rsp_stall <= (hold != 0);
         end else if (hold_left > 1) begin
            hold_left <= hold_left - 1;
         end else begin
            hold_left <= 0;
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: a run that stops moving on both channels is a failure.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_fire || rsp_fire) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= StallLimit) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      int pick;
      bit pressed;
      pressed = 1'b0;

      // Directed opening. The preamble is still going out, so every load here must
      // be refused. A take with nothing received must be harmless, and a single
      // low tick starts a reception that runs on into the random ticks below.
      add_tick(1'b1, 1'b1, 8'hFF, 1'b1);
      add_tick(1'b1, 1'b1, 8'h00, 1'b0);
      add_tick(1'b1, 1'b1, 8'h55, 1'b1);
      add_tick(1'b1, 1'b1, 8'hAA, 1'b0);
      add_tick(1'b0, 1'b0, 8'h00, 1'b0);
      add_tick(1'b1, 1'b1, 8'h80, 1'b1);
      add_tick(1'b1, 1'b1, 8'h01, 1'b0);
      add_tick(1'b1, 1'b0, 8'hFF, 1'b1);
      add_tick(1'b1, 1'b1, 8'h7F, 1'b0);
      add_tick(1'b1, 1'b1, 8'hFE, 1'b1);
      add_tick(1'b1, 1'b0, 8'h00, 1'b0);
      add_tick(1'b1, 1'b0, 8'h00, 1'b0);

      // Pause the sender until the directed ticks have all been answered.
      settle_next = 1'b1;

      // Random part: mostly well-formed frames with random data, so the receiver
      // spends its time deep in the data and stop stages. Some frames carry a low
      // stop bit, idle runs shift the start phase around, and short bursts of
      // noise break frames up. Random loads fill the transmitter once the preamble
      // is gone, and random takes sometimes collide with a latch or miss a byte so
      // that it is overwritten.
      while (ticks_made < TickTarget) begin
         quiet_now = ($urandom_range(0, 4) == 0);
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            send_frame(8'($urandom_range(0, 255)), 1'b1);
         end else if (pick == 6) begin
            send_frame(8'($urandom_range(0, 255)), 1'b0);
         end else if (pick < 9) begin
            repeat ($urandom_range(1, 12)) add_line(1'b1);
         end else begin
            repeat ($urandom_range(1, 8)) add_line(1'($urandom_range(0, 1)));
         end
         if (!pressed && ticks_made > TickTarget / 2) begin
            settle_next = 1'b1;
            pressed = 1'b1;
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Wait for every tick to go in and every status to come back, then let the clock
      // run on so that any stray item from the output register can show.
      while (tick_q.size() != 0 || req_valid || status_due_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
      if (status_due_q.size() != 0) begin
         fail_count++;
         $display("%0t ns: %0d status items never arrived", $time, status_due_q.size());
      end
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
